### sv/matrix_vector_multiply_bias_core_macros.svh
// assertion helpers for the dense layer core
`ifndef MATRIX_VECTOR_MULTIPLY_BIAS_CORE_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_BIAS_CORE_MACROS_SVH

// checked only out of reset
`define MVB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define MVB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/mvb_pkg.sv
package mvb_pkg;

    localparam int LEN_W       = 11;
    localparam int OPND_W      = 16;
    localparam int BIAS_W      = 32;
    localparam int RES_W       = 32;
    localparam int ROW_IDX_W   = 10;
    localparam int OP_W        = 2;
    localparam int REG_IDX_W   = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;

    localparam int DEF_MAX_IN    = 1024;
    localparam int DEF_MAX_OUT   = 1024;
    localparam int DEF_ACC_WIDTH = 48;

    localparam logic [LEN_W-1:0] RST_INPUT_LENGTH  = 11'd1024;
    localparam logic [LEN_W-1:0] RST_OUTPUT_LENGTH = 11'd1024;

    localparam logic [RES_W-1:0] RES_MAX = 32'h7fff_ffff;
    localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_ACT    = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INPUT_LENGTH  = 2'd0,
        REG_OUTPUT_LENGTH = 2'd1,
        REG_BIAS_ENABLE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                 valid;
        logic                 row_end;
        logic                 bias_en;
        logic                 last_row;
        logic [ROW_IDX_W-1:0] row_idx;
        logic [OPND_W-1:0]    weight;
    } issue_t;

endpackage

### sv/mvb_store.sv
module mvb_store #(
    parameter int DEPTH = mvb_pkg::DEF_MAX_IN,
    parameter int WIDTH = mvb_pkg::OPND_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import mvb_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/mvb_ctrl.sv
module mvb_ctrl #(
    parameter int MAX_IN  = mvb_pkg::DEF_MAX_IN,
    parameter int MAX_OUT = mvb_pkg::DEF_MAX_OUT,
    localparam int IA     = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
    localparam int OA     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mvb_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [mvb_pkg::LEN_W-1:0]       cfg_wdata,
    input  logic                            accept,
    input  logic [mvb_pkg::OP_W-1:0]        op,
    input  logic [mvb_pkg::OPND_W-1:0]      operand,
    output logic                            act_we,
    output logic [IA-1:0]                   act_waddr,
    output logic [IA-1:0]                   act_raddr,
    output logic                            bias_we,
    output logic [OA-1:0]                   bias_waddr,
    output logic [OA-1:0]                   bias_raddr,
    output mvb_pkg::issue_t                 issue
);
    import mvb_pkg::*;

    localparam int NIW = ($clog2(MAX_IN + 1) > LEN_W) ? $clog2(MAX_IN + 1) : LEN_W;
    localparam int NOW = ($clog2(MAX_OUT + 1) > LEN_W) ? $clog2(MAX_OUT + 1) : LEN_W;

    logic [LEN_W-1:0] in_len_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             bias_en_reg;

    logic [IA-1:0] col_reg, col_next;
    logic [OA-1:0] row_reg, row_next;
    logic [IA-1:0] awi_reg, awi_next;
    logic [OA-1:0] bwi_reg, bwi_next;

    logic [NIW-1:0] nin;
    logic [NOW-1:0] nout;
    logic [IA-1:0]  col_eff, awi_eff;
    logic [OA-1:0]  row_eff, bwi_eff;
    logic [NIW-1:0] col_inc, awi_inc;
    logic [NOW-1:0] row_inc, bwi_inc;
    logic           row_end, last_row;
    logic           is_act, is_weight, is_bias;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_len_reg  <= RST_INPUT_LENGTH;
            out_len_reg <= RST_OUTPUT_LENGTH;
            bias_en_reg <= 1'b0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_INPUT_LENGTH:  in_len_reg  <= cfg_wdata;
                REG_OUTPUT_LENGTH: out_len_reg <= cfg_wdata;
                REG_BIAS_ENABLE:   bias_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective lengths: zero acts as one, capped at the store depth
    always_comb begin
        if (in_len_reg == '0) begin
            nin = NIW'(1);
        end else if (NIW'(in_len_reg) > NIW'(MAX_IN)) begin
            nin = NIW'(MAX_IN);
        end else begin
            nin = NIW'(in_len_reg);
        end
        if (out_len_reg == '0) begin
            nout = NOW'(1);
        end else if (NOW'(out_len_reg) > NOW'(MAX_OUT)) begin
            nout = NOW'(MAX_OUT);
        end else begin
            nout = NOW'(out_len_reg);
        end
    end

    always_comb begin
        col_eff  = (NIW'(col_reg) >= nin) ? IA'(nin - NIW'(1)) : col_reg;
        row_eff  = (NOW'(row_reg) >= nout) ? OA'(nout - NOW'(1)) : row_reg;
        awi_eff  = (NIW'(awi_reg) >= nin) ? '0 : awi_reg;
        bwi_eff  = (NOW'(bwi_reg) >= nout) ? '0 : bwi_reg;
        col_inc  = NIW'(col_eff) + NIW'(1);
        row_inc  = NOW'(row_eff) + NOW'(1);
        awi_inc  = NIW'(awi_eff) + NIW'(1);
        bwi_inc  = NOW'(bwi_eff) + NOW'(1);
        row_end  = (col_inc >= nin);
        last_row = (row_inc >= nout);
    end

    always_comb begin
        is_act    = 1'b0;
        is_weight = 1'b0;
        is_bias   = 1'b0;
        case (op_t'(op))
            OP_ACT:    is_act    = 1'b1;
            OP_WEIGHT: is_weight = 1'b1;
            OP_BIAS:   is_bias   = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        awi_next = awi_reg;
        bwi_next = bwi_reg;
        if (accept && is_act) begin
            awi_next = (awi_inc >= nin) ? '0 : IA'(awi_inc);
        end
        if (accept && is_bias) begin
            bwi_next = (bwi_inc >= nout) ? '0 : OA'(bwi_inc);
        end
        if (accept && is_weight) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : OA'(row_inc);
            end else begin
                col_next = IA'(col_inc);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            awi_reg <= '0;
            bwi_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            awi_reg <= awi_next;
            bwi_reg <= bwi_next;
        end
    end

    assign act_we     = accept && is_act;
    assign act_waddr  = awi_eff;
    assign act_raddr  = col_eff;
    assign bias_we    = accept && is_bias;
    assign bias_waddr = bwi_eff;
    assign bias_raddr = row_eff;

    always_comb begin
        issue.valid    = accept && is_weight;
        issue.row_end  = row_end;
        issue.bias_en  = bias_en_reg;
        issue.last_row = last_row;
        issue.row_idx  = ROW_IDX_W'(row_eff);
        issue.weight   = operand;
    end

endmodule

### sv/mvb_mac.sv
module mvb_mac #(
    parameter int ACC_WIDTH = mvb_pkg::DEF_ACC_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mvb_pkg::issue_t                 issue,
    input  logic [mvb_pkg::OPND_W-1:0]      act_rdata,
    input  logic [mvb_pkg::BIAS_W-1:0]      bias_rdata,
    input  logic                            m_tready,
    output logic                            en,
    output logic                            m_valid,
    output logic [mvb_pkg::RES_W-1:0]       m_result,
    output logic [mvb_pkg::ROW_IDX_W-1:0]   m_row_idx,
    output logic                            m_last_row,
    output logic                            m_saturated
);
    import mvb_pkg::*;

    localparam int EW = ACC_WIDTH + 1;

    issue_t s1_reg;

    logic                    v2_reg, end2_reg, ben2_reg, last2_reg;
    logic [ROW_IDX_W-1:0]    row2_reg;
    logic signed [RES_W-1:0] p2_reg;
    logic signed [BIAS_W-1:0] bias2_reg;

    logic signed [ACC_WIDTH-1:0] acc_reg, acc_sum;

    logic                        v3_reg, last3_reg;
    logic [ROW_IDX_W-1:0]        row3_reg;
    logic signed [ACC_WIDTH-1:0] sum3_reg;
    logic signed [BIAS_W-1:0]    bias3_reg;

    logic signed [EW-1:0] total;
    logic                 sat_hi, sat_lo;
    logic [RES_W-1:0]     clipped;

    logic                 m_valid_reg, m_last_reg, m_sat_reg;
    logic [RES_W-1:0]     m_result_reg;
    logic [ROW_IDX_W-1:0] m_row_reg;

    assign en = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            s1_reg <= issue;
            v2_reg <= s1_reg.valid;
            v3_reg <= v2_reg && end2_reg;
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg    <= $signed(s1_reg.weight) * $signed(act_rdata);
            bias2_reg <= $signed(bias_rdata);
            end2_reg  <= s1_reg.row_end;
            ben2_reg  <= s1_reg.bias_en;
            last2_reg <= s1_reg.last_row;
            row2_reg  <= s1_reg.row_idx;
        end
    end

    // accumulate stage
    assign acc_sum = acc_reg + ACC_WIDTH'(p2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (en && v2_reg) begin
            acc_reg <= end2_reg ? '0 : acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum3_reg  <= acc_sum;
            bias3_reg <= ben2_reg ? bias2_reg : '0;
            row3_reg  <= row2_reg;
            last3_reg <= last2_reg;
        end
    end

    // bias add and clip to 32 bits
    always_comb begin
        total  = EW'(sum3_reg) + EW'(bias3_reg);
        sat_hi = !total[EW-1] && (|total[EW-2:RES_W-1]);
        sat_lo = total[EW-1] && !(&total[EW-2:RES_W-1]);
        if (sat_hi) begin
            clipped = RES_MAX;
        end else if (sat_lo) begin
            clipped = RES_MIN;
        end else begin
            clipped = total[RES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && v3_reg) begin
            m_result_reg <= clipped;
            m_row_reg    <= row3_reg;
            m_last_reg   <= last3_reg;
            m_sat_reg    <= sat_hi || sat_lo;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_result    = m_result_reg;
    assign m_row_idx   = m_row_reg;
    assign m_last_row  = m_last_reg;
    assign m_saturated = m_sat_reg;

endmodule

### sv/matrix_vector_multiply_bias_core.sv
// Dense layer y = W*x (+ bias) in fixed point, Q4.12 inputs and Q8.24 results.
// Input channel s_*: one beat per item, s_tuser selects activation, weight or
// bias. Activations and biases are written in order into two simple dual-port
// stores; weights then stream row-major and each one is multiplied by the
// activation of its column and added into the accumulator.
// A result beat on m_* follows the last weight of each row: m_tdata holds the
// saturated row value and row index, m_tlast marks the final row and m_tuser
// flags saturation.
// Throughput: one item per cycle unless m_tready stalls the output, set by one
// store read per beat feeding a four-stage read / multiply / accumulate /
// bias-and-clip pipeline, which carries each row's result beat after its last weight.
// Reset clears counters, accumulator and bias enable and sets lengths to (1024, 1024);
// the stores hold no reset value: the user must read them only after writing them.
// When m_tready is low with a result held, the whole pipeline freezes and
// s_tready drops; nothing is lost or repeated.
// Config writes take effect at once and belong between frames.
`include "matrix_vector_multiply_bias_core_macros.svh"

module matrix_vector_multiply_bias_core #(
    parameter int MAX_IN    = mvb_pkg::DEF_MAX_IN,
    parameter int MAX_OUT   = mvb_pkg::DEF_MAX_OUT,
    parameter int ACC_WIDTH = mvb_pkg::DEF_ACC_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mvb_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [mvb_pkg::LEN_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mvb_pkg::S_TDATA_W-1:0]   s_tdata,  // operand, bias_value
    input  logic [mvb_pkg::OP_W-1:0]        s_tuser,  // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mvb_pkg::M_TDATA_W-1:0]   m_tdata,  // row_result, row_index, zero pad
    output logic                            m_tlast,
    output logic                            m_tuser   // saturated
);
    import mvb_pkg::*;

    localparam int IA  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int OA  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int PAD = M_TDATA_W - RES_W - ROW_IDX_W;

    logic                  en, accept;
    logic                  act_we, bias_we;
    logic [IA-1:0]         act_waddr, act_raddr;
    logic [OA-1:0]         bias_waddr, bias_raddr;
    logic [OPND_W-1:0]     operand, act_rdata;
    logic [BIAS_W-1:0]     bias_value, bias_rdata;
    issue_t                issue;
    logic [RES_W-1:0]      row_result;
    logic [ROW_IDX_W-1:0]  row_index;

    assign operand    = s_tdata[OPND_W-1:0];
    assign bias_value = s_tdata[OPND_W+BIAS_W-1:OPND_W];
    assign s_tready   = en;
    assign accept     = s_tvalid && en;

    mvb_ctrl #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .op         (s_tuser),
        .operand    (operand),
        .act_we     (act_we),
        .act_waddr  (act_waddr),
        .act_raddr  (act_raddr),
        .bias_we    (bias_we),
        .bias_waddr (bias_waddr),
        .bias_raddr (bias_raddr),
        .issue      (issue)
    );

    mvb_store #(
        .DEPTH (MAX_IN),
        .WIDTH (OPND_W)
    ) u_act_store (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (operand),
        .re    (en),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    mvb_store #(
        .DEPTH (MAX_OUT),
        .WIDTH (BIAS_W)
    ) u_bias_store (
        .aclk  (aclk),
        .we    (bias_we),
        .waddr (bias_waddr),
        .wdata (bias_value),
        .re    (en),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    mvb_mac #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .act_rdata   (act_rdata),
        .bias_rdata  (bias_rdata),
        .m_tready    (m_tready),
        .en          (en),
        .m_valid     (m_tvalid),
        .m_result    (row_result),
        .m_row_idx   (row_index),
        .m_last_row  (m_tlast),
        .m_saturated (m_tuser)
    );

    assign m_tdata = {{PAD{1'b0}}, row_index, row_result};

    `MVB_ASSERT(a_result_loads_only_when_free, $rose(m_tvalid) |-> $past(s_tready),
        "result beat appeared while pipeline was frozen")
    `MVB_ASSERT(a_saturated_value, (m_tvalid && m_tuser) |->
        (m_tdata[RES_W-1:0] == RES_MAX || m_tdata[RES_W-1:0] == RES_MIN),
        "saturation flag without clipped value")
    `MVB_ASSERT_ALWAYS(a_reset_clears_result, !aresetn |=> !m_tvalid,
        "result beat valid right after reset")

endmodule
